FILE: rtl/core/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants of the heat diffusion stencil
// Holds grid limits, field widths, register indexes and the structs that
// travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package hds_pkg;

   // grid limits
   localparam int MAX_COLS = 128;
   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int COLS_W   = COL_BITS + 1;
   localparam int MAX_ROWS = 1024;
   localparam int ROW_BITS = $clog2(MAX_ROWS);
   localparam int ROWS_W   = ROW_BITS + 1;
   localparam int MIN_DIM  = 3;

   // raster index and cell count of one frame
   localparam int OIDX_BITS = COL_BITS + ROW_BITS;
   localparam int TOTAL_W   = OIDX_BITS + 1;

   // temperature and arithmetic widths
   localparam int TEMP_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int LAP_W     = TEMP_BITS + 3;
   localparam int COEFF_W   = 15;
   localparam int PROD_W    = LAP_W + COEFF_W + 1;
   localparam int DELTA_W   = PROD_W - FRAC_BITS;
   localparam int SUM_W     = DELTA_W + 1;
   localparam int COEFF_MAX = 16384;

   // configuration register file
   localparam int GCOLS_W    = 8;
   localparam int GROWS_W    = 11;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COEFF     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_TEMP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd3;

   localparam logic [COEFF_W-1:0]   COEFF_RESET     = 15'd2621;
   localparam logic [TEMP_BITS-1:0] EDGE_TEMP_RESET = 16'd12800;
   localparam logic [GCOLS_W-1:0]   GRID_COLS_RESET = 8'd100;
   localparam logic [GROWS_W-1:0]   GRID_ROWS_RESET = 11'd100;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_BITS + 1;

   // channel payloads
   typedef struct packed {
      logic                 kind;
      logic [TEMP_BITS-1:0] cell_temp;
   } hds_req_type;

   typedef struct packed {
      logic [TEMP_BITS-1:0] new_temp;
      logic                 frame_end;
   } hds_rsp_type;

   // decoded configuration seen by the front end
   typedef struct packed {
      logic [TEMP_BITS-1:0] edge_temp;
      logic [COL_BITS-1:0]  last_col;
      logic [ROW_BITS-1:0]  last_row;
      logic [TOTAL_W-1:0]   total;
      logic                 restart;
   } hds_csr_type;

   // one result to compute: operands of the stencil or a forced edge value
   typedef struct packed {
      logic                 edge_cell;
      logic                 frame_end;
      logic [TEMP_BITS-1:0] north;
      logic [TEMP_BITS-1:0] south;
      logic [TEMP_BITS-1:0] east;
      logic [TEMP_BITS-1:0] west;
      logic [TEMP_BITS-1:0] center;
   } hds_cmd_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } hds_queue_status_type;

   typedef struct packed {
      logic f1_busy;
   } hds_front_status_type;

endpackage

FILE: rtl/core/hds_ram.sv
// ----------------------------------------------------------------------------
// hds_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/hds_front.sv
// ----------------------------------------------------------------------------
// hds_front: input side of the stencil
// Tracks the raster position, classifies each item, keeps the two line
// buffers and the 3-cell window, and pushes one command per result.
// ----------------------------------------------------------------------------
module hds_front
   import hds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hds_req_type          req_data,
   input  hds_csr_type          csr,
   input  logic [QCNT_W-1:0]    q_count,
   output logic                 push,
   output hds_cmd_type          push_cmd,
   output hds_front_status_type status
);

   // position and result index
   logic [ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0]  in_col_ff, in_col_in;
   logic [OIDX_BITS-1:0] out_index_ff, out_index_in;

   // second stage, waiting on line buffer data
   logic                 f1_valid_ff, f1_valid_in;
   logic                 f1_sample_ff;
   logic                 f1_emit_ff;
   logic                 f1_edge_ff;
   logic                 f1_last_ff;
   logic [COL_BITS-1:0]  f1_col_ff;
   logic [TEMP_BITS-1:0] f1_temp_ff;

   // window: north, center, west, and the cell south of the center
   logic [TEMP_BITS-1:0] win_north_ff;
   logic [TEMP_BITS-1:0] win_center_ff;
   logic [TEMP_BITS-1:0] win_west_ff;
   logic [TEMP_BITS-1:0] south_ff;

   logic [TEMP_BITS-1:0] up_rd;
   logic [TEMP_BITS-1:0] mid_rd;

   logic [QCNT_W-1:0]    occupancy;
   logic                 accept;
   logic                 is_sample;
   logic                 at_origin;
   logic                 col_zero;
   logic                 smp_emit;
   logic                 smp_edge;
   logic                 flush_emit;
   logic                 flush_last;
   logic [OIDX_BITS-1:0] base_index;
   logic                 line_write;

   // credit check: queue entries plus the one in flight
   assign occupancy = q_count + QCNT_W'(f1_valid_ff);
   assign req_stall = occupancy >= QCNT_W'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // classify the item at the current raster position
   always_comb begin
      is_sample  = req_data.kind == KIND_SAMPLE;
      col_zero   = in_col_ff == '0;
      at_origin  = (in_row_ff == '0) && col_zero;
      smp_emit   = ((in_row_ff != '0) && !col_zero) ||
                   (col_zero && (in_row_ff > ROW_BITS'(1)));
      smp_edge   = col_zero || (in_row_ff == ROW_BITS'(1)) ||
                   (in_col_ff == COL_BITS'(1));
      flush_emit = at_origin && (out_index_ff != '0) &&
                   ({1'b0, out_index_ff} < csr.total);
      flush_last = {1'b0, out_index_ff} == (csr.total - TOTAL_W'(1));
      base_index = at_origin ? '0 : out_index_ff;
   end

   // next position and result index
   always_comb begin
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      out_index_in = out_index_ff;
      if (csr.restart) begin
         in_row_in    = '0;
         in_col_in    = '0;
         out_index_in = '0;
      end else if (accept && is_sample) begin
         out_index_in = smp_emit ? base_index + OIDX_BITS'(1) : base_index;
         if (in_col_ff == csr.last_col) begin
            in_col_in = '0;
            in_row_in = (in_row_ff == csr.last_row) ? '0 : in_row_ff + ROW_BITS'(1);
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
      end else if (accept && flush_emit) begin
         out_index_in = flush_last ? '0 : out_index_ff + OIDX_BITS'(1);
      end
   end

   assign f1_valid_in = accept && (is_sample || flush_emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_index_ff <= '0;
         f1_valid_ff  <= 1'b0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_index_ff <= out_index_in;
         f1_valid_ff  <= f1_valid_in;
      end
   end

   // item details for the second stage
   always_ff @(posedge clock) begin
      if (accept) begin
         f1_sample_ff <= is_sample;
         f1_emit_ff   <= is_sample ? smp_emit : 1'b1;
         f1_edge_ff   <= is_sample ? smp_edge : 1'b1;
         f1_last_ff   <= !is_sample && flush_last;
         f1_col_ff    <= in_col_ff;
         f1_temp_ff   <= req_data.cell_temp;
      end
   end

   // line buffers: read on transfer, shift down one row in the following cycle
   assign line_write = f1_valid_ff && f1_sample_ff;

   hds_ram #(
      .WIDTH (TEMP_BITS),
      .DEPTH (MAX_COLS)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (line_write),
      .wr_addr (f1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (up_rd)
   );

   hds_ram #(
      .WIDTH (TEMP_BITS),
      .DEPTH (MAX_COLS)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (line_write),
      .wr_addr (f1_col_ff),
      .wr_data (f1_temp_ff),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   // window shift on every sample
   always_ff @(posedge clock) begin
      if (reset) begin
         win_north_ff  <= '0;
         win_center_ff <= '0;
         win_west_ff   <= '0;
      end else if (line_write) begin
         win_west_ff   <= win_center_ff;
         win_center_ff <= mid_rd;
         win_north_ff  <= up_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (line_write) begin
         south_ff <= f1_temp_ff;
      end
   end

   // command for the back end
   always_comb begin
      push               = f1_valid_ff && f1_emit_ff;
      push_cmd.edge_cell = f1_edge_ff;
      push_cmd.frame_end = f1_last_ff;
      push_cmd.north     = win_north_ff;
      push_cmd.south     = south_ff;
      push_cmd.east      = mid_rd;
      push_cmd.west      = win_west_ff;
      push_cmd.center    = f1_edge_ff ? csr.edge_temp : win_center_ff;
   end

   assign status.f1_busy = f1_valid_ff;

endmodule

FILE: rtl/core/hds_queue.sv
// ----------------------------------------------------------------------------
// hds_queue: command queue between front and back end
// Small circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module hds_queue
   import hds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hds_cmd_type          push_cmd,
   input  logic                 pop,
   output hds_cmd_type          pop_cmd,
   output hds_queue_status_type status
);

   hds_cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

endmodule

FILE: rtl/core/hds_back.sv
// ----------------------------------------------------------------------------
// hds_back: stencil arithmetic and result register
// Laplacian, multiply by the coefficient, round and saturate, one stage each.
// The whole pipe holds while a result waits on the output.
// ----------------------------------------------------------------------------
module hds_back
   import hds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [COEFF_W-1:0]   coeff,
   input  hds_cmd_type          pop_cmd,
   input  hds_queue_status_type q_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hds_rsp_type          rsp_data
);

   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

   logic                     advance;

   // stage 1: laplacian
   logic                     b1_valid_ff;
   logic signed [LAP_W-1:0]  b1_lap_ff, b1_lap_in;
   logic [TEMP_BITS-1:0]     b1_center_ff;
   logic                     b1_edge_ff;
   logic                     b1_last_ff;
   logic [TEMP_BITS+1:0]     sum4;

   // stage 2: product
   logic                     b2_valid_ff;
   logic signed [PROD_W-1:0] b2_prod_ff, b2_prod_in;
   logic [TEMP_BITS-1:0]     b2_center_ff;
   logic                     b2_edge_ff;
   logic                     b2_last_ff;
   logic signed [COEFF_W:0]  coeff_s;

   // stage 3: round, add, saturate
   logic                     rsp_valid_ff;
   hds_rsp_type              rsp_data_ff, rsp_data_in;
   logic signed [PROD_W-1:0] rounded;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]  updated;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !q_status.empty;

   // four-neighbor sum minus four times the center
   always_comb begin
      sum4 = {2'b00, pop_cmd.north} + {2'b00, pop_cmd.south} +
             {2'b00, pop_cmd.east} + {2'b00, pop_cmd.west};
      b1_lap_in = $signed({1'b0, sum4}) - $signed({1'b0, pop_cmd.center, 2'b00});
   end

   // scale by the coefficient
   always_comb begin
      coeff_s    = $signed({1'b0, coeff});
      b2_prod_in = b1_lap_ff * coeff_s;
   end

   // round half up, add to the center, clamp to the temperature range; edge cells keep the center
   always_comb begin
      rounded = b2_prod_ff + HALF_LSB;
      delta   = $signed(rounded[PROD_W-1:FRAC_BITS]);
      updated = $signed({{(SUM_W-TEMP_BITS){1'b0}}, b2_center_ff}) +
                $signed({delta[DELTA_W-1], delta});
      rsp_data_in.frame_end = b2_last_ff;
      if (b2_edge_ff) begin
         rsp_data_in.new_temp = b2_center_ff;
      end else if (updated[SUM_W-1]) begin
         rsp_data_in.new_temp = '0;
      end else if (updated[SUM_W-2:TEMP_BITS] != '0) begin
         rsp_data_in.new_temp = '1;
      end else begin
         rsp_data_in.new_temp = updated[TEMP_BITS-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= pop;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (pop) begin
         b1_lap_ff    <= b1_lap_in;
         b1_center_ff <= pop_cmd.center;
         b1_edge_ff   <= pop_cmd.edge_cell;
         b1_last_ff   <= pop_cmd.frame_end;
      end
      if (advance && b1_valid_ff) begin
         b2_prod_ff   <= b2_prod_in;
         b2_center_ff <= b1_center_ff;
         b2_edge_ff   <= b1_edge_ff;
         b2_last_ff   <= b1_last_ff;
      end
      if (advance && b2_valid_ff) begin
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/heat_diffusion_stencil_top.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_top: one FTCS time step of 2D heat diffusion
// Takes one cell or flush item per cycle while req_stall is low; results leave
// the back end one per cycle while the output is not stalled.
// The front end keeps up to 4 commands in flight, set by the command queue.
// Reset is synchronous: position, window and registers return to defaults;
// the line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_top
   import hds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hds_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hds_rsp_type           rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [COEFF_W-1:0]   coeff_ff;
   logic [TEMP_BITS-1:0] edge_temp_ff;
   logic [GCOLS_W-1:0]   grid_cols_ff;
   logic [GROWS_W-1:0]   grid_rows_ff;
   logic [TOTAL_W-1:0]   total_ff, total_in;

   logic [COLS_W-1:0]    cols_used;
   logic [ROWS_W-1:0]    rows_used;
   logic [COEFF_W-1:0]   coeff_used;

   hds_csr_type          csr;
   hds_cmd_type          push_cmd;
   hds_cmd_type          pop_cmd;
   hds_queue_status_type q_status;
   hds_front_status_type front_status;
   logic                 q_push;
   logic                 q_pop;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff     <= COEFF_RESET;
         edge_temp_ff <= EDGE_TEMP_RESET;
         grid_cols_ff <= GRID_COLS_RESET;
         grid_rows_ff <= GRID_ROWS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_COEFF:     coeff_ff     <= csr_wdata[COEFF_W-1:0];
            CSR_EDGE_TEMP: edge_temp_ff <= csr_wdata[TEMP_BITS-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[GCOLS_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[GROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp grid size and coefficient to their legal ranges
   always_comb begin
      if (grid_cols_ff < GCOLS_W'(MIN_DIM)) begin
         cols_used = COLS_W'(MIN_DIM);
      end else if (grid_cols_ff > GCOLS_W'(MAX_COLS)) begin
         cols_used = COLS_W'(MAX_COLS);
      end else begin
         cols_used = COLS_W'(grid_cols_ff);
      end
      if (grid_rows_ff < GROWS_W'(MIN_DIM)) begin
         rows_used = ROWS_W'(MIN_DIM);
      end else if (grid_rows_ff > GROWS_W'(MAX_ROWS)) begin
         rows_used = ROWS_W'(MAX_ROWS);
      end else begin
         rows_used = ROWS_W'(grid_rows_ff);
      end
      coeff_used = (coeff_ff > COEFF_W'(COEFF_MAX)) ? COEFF_W'(COEFF_MAX) : coeff_ff;
      total_in   = TOTAL_W'(cols_used) * TOTAL_W'(rows_used);
   end

   // cell count of one frame
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // decoded configuration for the front end
   always_comb begin
      csr.edge_temp = edge_temp_ff;
      csr.last_col  = COL_BITS'(cols_used - COLS_W'(1));
      csr.last_row  = ROW_BITS'(rows_used - ROWS_W'(1));
      csr.total     = total_ff;
      csr.restart   = csr_write_en &&
                      ((csr_index == CSR_GRID_COLS) || (csr_index == CSR_GRID_ROWS));
   end

   hds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr       (csr),
      .q_count   (q_status.count),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .status    (front_status)
   );

   hds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   hds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coeff     (coeff_used),
      .pop_cmd   (pop_cmd),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("command pushed into a full queue");

   // queue never underflows
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("command popped from an empty queue");

   // front end credit covers every command in flight
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (q_status.count + QCNT_W'(front_status.f1_busy)) <= QCNT_W'(QUEUE_DEPTH))
      else $error("commands in flight exceed queue depth");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the heat diffusion stencil
// Streams grid cells and flush ticks over several grid sizes and coefficient
// settings, predicts each new temperature with a cycle-free stencil model
// and checks every result transfer in order against it.
// ----------------------------------------------------------------------------
module tb;
   import hds_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   hds_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   hds_rsp_type           rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heat_diffusion_stencil_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register mirror
   bit [COEFF_W-1:0]   coeff_reg = COEFF_RESET;
   bit [TEMP_BITS-1:0] edge_reg  = EDGE_TEMP_RESET;
   bit [GCOLS_W-1:0]   cols_reg  = GRID_COLS_RESET;
   bit [GROWS_W-1:0]   rows_reg  = GRID_ROWS_RESET;

   // stencil model state
   bit [TEMP_BITS-1:0] upper_row  [MAX_COLS];
   bit [TEMP_BITS-1:0] middle_row [MAX_COLS];
   bit [TEMP_BITS-1:0] win_north  = '0;
   bit [TEMP_BITS-1:0] win_center = '0;
   bit [TEMP_BITS-1:0] win_west   = '0;
   int unsigned        next_row   = 0;
   int unsigned        next_col   = 0;
   int unsigned        out_cell   = 0;

   hds_req_type pending_items [$];
   hds_rsp_type temps_due [$];
   int unsigned mismatch_count = 0;
   int unsigned cells_sent = 0;
   bit          bursts_on = 1'b1;
   bit          req_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;

   function automatic hds_req_type make_item(input logic kind, input logic [TEMP_BITS-1:0] temp);
      hds_req_type item;
      item.kind = kind;
      item.cell_temp = temp;
      return item;
   endfunction

   // one item through the stencil; returns 1 when it releases a result
   function automatic bit step_stencil(input hds_req_type item, output hds_rsp_type res);
      int unsigned        cols, rows, total, ir, ic, orow, ocol;
      bit [TEMP_BITS-1:0] old_up, old_mid, val;
      bit                 emit;
      longint             lap, coef, delta, sum;
      cols = (cols_reg < MIN_DIM) ? MIN_DIM : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      rows = (rows_reg < MIN_DIM) ? MIN_DIM : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      total = cols * rows;
      res = '0;
      emit = 1'b0;
      val = '0;
      orow = 0;
      ocol = 0;
      // flush releases one pending edge cell once the whole frame is in
      if (item.kind == KIND_FLUSH) begin
         if (next_row == 0 && next_col == 0 && out_cell != 0 && out_cell < total) begin
            res.new_temp = edge_reg;
            res.frame_end = (out_cell == total - 1);
            out_cell = res.frame_end ? 0 : out_cell + 1;
            return 1'b1;
         end
         return 1'b0;
      end
      if (next_row >= rows || next_col >= cols) begin
         next_row = 0;
         next_col = 0;
         out_cell = 0;
      end
      ir = next_row;
      ic = next_col;
      // first sample of a frame drops what is left of the previous one
      if (ir == 0 && ic == 0) out_cell = 0;
      old_up = upper_row[ic];
      old_mid = middle_row[ic];
      upper_row[ic] = old_mid;
      middle_row[ic] = item.cell_temp;
      if (ic >= 1 && ir >= 1) begin
         orow = ir - 1;
         ocol = ic - 1;
         emit = 1'b1;
      end else if (ic == 0 && ir >= 2) begin
         orow = ir - 2;
         ocol = cols - 1;
         emit = 1'b1;
      end
      if (emit) begin
         if (orow == 0 || orow == rows - 1 || ocol == 0 || ocol == cols - 1) begin
            val = edge_reg;
         end else begin
            // C + r*(N+S+E+W-4C), rounded half up, saturated
            lap = longint'(win_north) + longint'(middle_row[ocol]) + longint'(old_mid)
                  + longint'(win_west) - 4 * longint'(win_center);
            coef = (coeff_reg > COEFF_MAX) ? COEFF_MAX : coeff_reg;
            delta = (lap * coef + 32768) >>> FRAC_BITS;
            sum = longint'(win_center) + delta;
            if (sum < 0) val = '0;
            else if (sum > 65535) val = '1;
            else val = sum[TEMP_BITS-1:0];
         end
      end
      win_west = win_center;
      win_center = old_mid;
      win_north = old_up;
      if (ic + 1 >= cols) begin
         next_col = 0;
         next_row = (ir + 1 >= rows) ? 0 : ir + 1;
      end else begin
         next_col = ic + 1;
      end
      if (emit) begin
         res.new_temp = val;
         res.frame_end = (orow * cols + ocol == total - 1);
         out_cell = orow * cols + ocol + 1;
      end
      return emit;
   endfunction

   // input driver, fed from pending_items
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 5) - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on input transfer, check on result transfer
   always @(posedge clock) begin : monitor
      hds_rsp_type want;
      hds_rsp_type got;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (step_stencil(req_data, want)) temps_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (temps_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result new_temp %h frame_end %b",
                           $realtime, got.new_temp, got.frame_end);
            end else begin
               want = temps_due.pop_front();
               if (got.new_temp !== want.new_temp || got.frame_end !== want.frame_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: new_temp exp %h got %h, frame_end exp %b got %b",
                              $realtime, want.new_temp, got.new_temp,
                              want.frame_end, got.frame_end);
               end
            end
         end
      end
   end

   // wait for the sender and all results, then let the pipeline empty
   task automatic settle();
      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (temps_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_COEFF:     coeff_reg = val[COEFF_W-1:0];
         CSR_EDGE_TEMP: edge_reg = val;
         CSR_GRID_COLS: begin
            cols_reg = val[GCOLS_W-1:0];
            next_row = 0;
            next_col = 0;
            out_cell = 0;
         end
         default: begin
            rows_reg = val[GROWS_W-1:0];
            next_row = 0;
            next_col = 0;
            out_cell = 0;
         end
      endcase
   endtask

   // raster cells with random content, the odd ignored flush, then flush ticks
   task automatic queue_frame(input int unsigned cells, input int unsigned flushes);
      int unsigned        style;
      bit [TEMP_BITS-1:0] base, t;
      style = $urandom_range(0, 3);
      base = TEMP_BITS'($urandom);
      for (int unsigned k = 0; k < cells; k++) begin
         case (style)
            0: t = TEMP_BITS'($urandom);
            1: t = TEMP_BITS'(base + $urandom_range(0, 511) - 256);
            2: t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: t = TEMP_BITS'(base + k * 37);
         endcase
         pending_items.push_back(make_item(KIND_SAMPLE, t));
         cells_sent++;
         if ($urandom_range(0, 24) == 0)
            pending_items.push_back(make_item(KIND_FLUSH, TEMP_BITS'($urandom)));
      end
      repeat (flushes) pending_items.push_back(make_item(KIND_FLUSH, TEMP_BITS'($urandom)));
   endtask

   initial begin : stimulus
      int unsigned cols, rows, fl;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: 4x3 checkerboard at full coefficient, hot edges
      write_reg(CSR_COEFF, 16'd16384);
      write_reg(CSR_EDGE_TEMP, 16'hFFFF);
      write_reg(CSR_GRID_COLS, 16'd4);
      write_reg(CSR_GRID_ROWS, 16'd3);
      pending_items.push_back(make_item(KIND_FLUSH, 16'hFFFF));
      for (int unsigned k = 0; k < 8; k++)
         pending_items.push_back(make_item(KIND_SAMPLE, ((k + k / 4) % 2) ? 16'hFFFF : 16'h0000));
      // flush before the frame is complete is ignored
      pending_items.push_back(make_item(KIND_FLUSH, 16'h0000));
      // hold the sender until every pending result is out
      settle();
      for (int unsigned k = 8; k < 12; k++)
         pending_items.push_back(make_item(KIND_SAMPLE, ((k + k / 4) % 2) ? 16'hFFFF : 16'h0000));
      repeat (6) pending_items.push_back(make_item(KIND_FLUSH, 16'h5A5A));
      cells_sent += 12;
      settle();

      // coefficient above range, cold edges, grid size clamped up to 3x3
      write_reg(CSR_COEFF, 16'hFFFF);
      write_reg(CSR_EDGE_TEMP, 16'h0000);
      write_reg(CSR_GRID_COLS, 16'd0);
      write_reg(CSR_GRID_ROWS, 16'd2);
      queue_frame(9, 4);
      queue_frame(9, 2);
      queue_frame(9, 6);
      settle();

      // widest grid, zero coefficient, part of a frame then dropped
      write_reg(CSR_COEFF, 16'd0);
      write_reg(CSR_EDGE_TEMP, CSR_DATA_W'($urandom));
      write_reg(CSR_GRID_COLS, 16'd128);
      write_reg(CSR_GRID_ROWS, 16'd0);
      queue_frame(264, 0);
      settle();

      // tallest grid, exact and clamped
      write_reg(CSR_COEFF, CSR_DATA_W'($urandom_range(0, 16384)));
      write_reg(CSR_GRID_COLS, 16'd3);
      write_reg(CSR_GRID_ROWS, 16'd1024);
      queue_frame(40, 0);
      settle();
      write_reg(CSR_GRID_COLS, 16'd1);
      write_reg(CSR_GRID_ROWS, 16'd2047);
      queue_frame(30, 1);
      settle();

      // random small grids
      while (cells_sent < 700) begin
         cols = $urandom_range(3, 10);
         rows = $urandom_range(3, 8);
         if ($urandom_range(0, 9) == 0) cols = $urandom_range(11, 40);
         settle();
         case ($urandom_range(0, 5))
            0: write_reg(CSR_COEFF, CSR_DATA_W'($urandom));
            1: write_reg(CSR_COEFF, 16'd16384);
            2, 3: write_reg(CSR_COEFF, CSR_DATA_W'($urandom_range(0, 16384)));
            default: ;
         endcase
         if ($urandom_range(0, 2) == 0) write_reg(CSR_EDGE_TEMP, CSR_DATA_W'($urandom));
         write_reg(CSR_GRID_COLS, CSR_DATA_W'(cols));
         write_reg(CSR_GRID_ROWS, CSR_DATA_W'(rows));
         repeat ($urandom_range(1, 3)) begin
            fl = cols + 1;
            case ($urandom_range(0, 5))
               4: fl = $urandom_range(0, cols);
               5: fl = cols + 1 + $urandom_range(1, 3);
               default: ;
            endcase
            queue_frame(cols * rows, fl);
         end
         // unfinished frame, dropped by the next size write
         if ($urandom_range(0, 3) == 0) queue_frame($urandom_range(1, cols * rows - 1), 0);
         if (cells_sent >= 620) bursts_on = 1'b0;
      end

      settle();
      if (mismatch_count == 0 && temps_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
